// File: sv/olist_pkg.sv
// shared types and constants for the ordered list engine
package olist_pkg;

   localparam int DEPTH  = 32;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [DEPTH-1:0]  slot_mask_type;

   typedef enum logic [2:0] {
      FN_INS_FRONT = 3'd0,
      FN_APPEND    = 3'd1,
      FN_INS_AT    = 3'd2,
      FN_DEL_FRONT = 3'd3,
      FN_DEL_BACK  = 3'd4,
      FN_DEL_AT    = 3'd5,
      FN_TRAVERSE  = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WALK,
      S_INS_FRONT,
      S_INS_NEW,
      S_INS_PREV,
      S_DEL_FRONT,
      S_DEL_LINK,
      S_TRAV,
      S_RESP
   } state_type;

   // one-hot mask of a single slot
   function automatic slot_mask_type slot_bit(input slot_type s);
      slot_mask_type m;
      m = slot_mask_type'(1) << s;
      return m;
   endfunction

endpackage

// File: sv/ordered_list_engine.sv
// ordered list engine: circular singly linked list held in slot memories
// sequence: refusals, unused codes and single-element operations go straight to the
//    response; front insert and delete pass through S_INS_FRONT or S_DEL_FRONT; insert
//    or delete at an index walks in S_WALK (append to position count, delete back to
//    count - 1), then relinks; the request side stalls until the result is loaded
// traverse gives one element a cycle while the output is not stalled
// reset: synchronous; list empty, all slots free; slot memories are not cleared
module ordered_list_engine (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_func,
   input  logic signed [31:0]       req_key,
   input  logic [5:0]               req_position,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [31:0]       rsp_element,
   output logic [5:0]               rsp_element_count,
   output logic                     rsp_last
);

   // ------------------------------------------------------------------
   // state registers
   // ------------------------------------------------------------------
   olist_pkg::state_type     state_ff, state_in;
   olist_pkg::slot_type      head_ff, head_in;
   olist_pkg::slot_type      tail_ff, tail_in;
   olist_pkg::slot_mask_type free_ff, free_in;
   olist_pkg::count_type     count_ff, count_in;

   // per-transaction working registers
   olist_pkg::slot_type      slot_ff, slot_in;      // newly allocated slot
   olist_pkg::slot_type      cur_ff, cur_in;        // walk cursor
   olist_pkg::slot_type      prev_ff, prev_in;      // one step behind the cursor
   olist_pkg::slot_type      prev2_ff, prev2_in;    // two steps behind
   olist_pkg::count_type     steps_ff, steps_in;    // walk steps or elements left
   logic                     del_ff, del_in;        // walk feeds a delete
   olist_pkg::status_type    status_ff, status_in;  // pending status transaction

   // response output register
   logic                     rsp_valid_ff, rsp_valid_in;
   olist_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic signed [31:0]       rsp_element_ff, rsp_element_in;
   olist_pkg::count_type     rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_load;
   logic                     out_free;

   // ------------------------------------------------------------------
   // slot memories: values and successor links, registered read
   // both share a read address so a traverse gets value and link together
   // ------------------------------------------------------------------
   logic signed [31:0]       val_mem [olist_pkg::DEPTH];
   olist_pkg::slot_type      link_mem [olist_pkg::DEPTH];
   logic signed [31:0]       val_rd_ff;
   olist_pkg::slot_type      link_rd_ff;

   logic                     val_we;
   logic                     link_we;
   olist_pkg::slot_type      link_wa;
   olist_pkg::slot_type      link_wd;
   olist_pkg::slot_type      mem_ra;

   // request decode
   olist_pkg::func_type      func;
   olist_pkg::slot_type      alloc_slot;
   olist_pkg::count_type     pos_eff;
   olist_pkg::count_type     req_pos;
   logic                     is_empty;
   logic                     is_full;
   logic                     do_ins;
   logic                     do_del;

   assign func     = olist_pkg::func_type'(req_func);
   assign req_pos  = olist_pkg::count_type'(req_position);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == olist_pkg::count_type'(olist_pkg::DEPTH));

   // lowest free slot
   always_comb begin
      alloc_slot = '0;
      for (int i = olist_pkg::DEPTH - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            alloc_slot = olist_pkg::slot_type'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[slot_in] <= req_key;
      end
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      val_rd_ff  <= val_mem[mem_ra];
      link_rd_ff <= link_mem[mem_ra];
   end

   // the output register frees up when empty or when its transaction is taken
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != olist_pkg::S_IDLE);

   // ------------------------------------------------------------------
   // request classification: which operation, and at which index
   // ------------------------------------------------------------------
   always_comb begin
      do_ins    = 1'b0;
      do_del    = 1'b0;
      pos_eff   = '0;
      status_in = olist_pkg::ST_OK;
      unique case (func)
         olist_pkg::FN_INS_FRONT: begin
            if (is_full) status_in = olist_pkg::ST_FULL;
            else         do_ins    = 1'b1;
         end
         olist_pkg::FN_APPEND: begin
            // append to an empty list is refused
            pos_eff = count_ff;
            if (is_empty)     status_in = olist_pkg::ST_EMPTY;
            else if (is_full) status_in = olist_pkg::ST_FULL;
            else              do_ins    = 1'b1;
         end
         olist_pkg::FN_INS_AT: begin
            pos_eff = req_pos;
            if (is_empty)              status_in = olist_pkg::ST_EMPTY;
            else if (is_full)          status_in = olist_pkg::ST_FULL;
            else if (req_pos > count_ff) status_in = olist_pkg::ST_RANGE;
            else                       do_ins    = 1'b1;
         end
         olist_pkg::FN_DEL_FRONT: begin
            if (is_empty) status_in = olist_pkg::ST_EMPTY;
            else          do_del    = 1'b1;
         end
         olist_pkg::FN_DEL_BACK: begin
            pos_eff = olist_pkg::count_type'(count_ff - 1'b1);
            if (is_empty) status_in = olist_pkg::ST_EMPTY;
            else          do_del    = 1'b1;
         end
         olist_pkg::FN_DEL_AT: begin
            pos_eff = req_pos;
            if (is_empty)                 status_in = olist_pkg::ST_EMPTY;
            else if (req_pos >= count_ff) status_in = olist_pkg::ST_RANGE;
            else                          do_del    = 1'b1;
         end
         olist_pkg::FN_TRAVERSE: begin
            if (is_empty) status_in = olist_pkg::ST_EMPTY;
         end
         default: begin
            // unused code: no operation, ok status
            status_in = olist_pkg::ST_OK;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // sequencer: next state, memory control and response loading
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      free_in  = free_ff;
      count_in = count_ff;
      slot_in  = slot_ff;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      prev2_in = prev2_ff;
      steps_in = steps_ff;
      del_in   = del_ff;

      val_we  = 1'b0;
      link_we = 1'b0;
      link_wa = slot_ff;
      link_wd = cur_ff;
      mem_ra  = cur_ff;

      rsp_load       = 1'b0;
      rsp_status_in  = status_ff;
      rsp_element_in = '0;
      rsp_count_in   = count_ff;
      rsp_last_in    = 1'b1;

      unique case (state_ff)
         olist_pkg::S_IDLE: begin
            // the head is read at acceptance: every walk and traverse starts there
            mem_ra = head_ff;
            if (req_valid) begin
               cur_in   = head_ff;
               state_in = olist_pkg::S_RESP;
               if (do_ins) begin
                  slot_in  = alloc_slot;
                  free_in  = free_ff & ~olist_pkg::slot_bit(alloc_slot);
                  val_we   = 1'b1;
                  count_in = olist_pkg::count_type'(count_ff + 1'b1);
                  link_wa  = alloc_slot;
                  if (is_empty) begin
                     // single element points at itself
                     link_we = 1'b1;
                     link_wd = alloc_slot;
                     head_in = alloc_slot;
                     tail_in = alloc_slot;
                  end else if (pos_eff == '0) begin
                     link_we  = 1'b1;
                     link_wd  = head_ff;
                     head_in  = alloc_slot;
                     state_in = olist_pkg::S_INS_FRONT;
                  end else begin
                     // walk to the slot at pos; its predecessor trails by one
                     steps_in = pos_eff;
                     del_in   = 1'b0;
                     state_in = olist_pkg::S_WALK;
                  end
               end else if (do_del) begin
                  count_in = olist_pkg::count_type'(count_ff - 1'b1);
                  if (count_ff == olist_pkg::count_type'(1)) begin
                     free_in = free_ff | olist_pkg::slot_bit(head_ff);
                     head_in = '0;
                     tail_in = '0;
                  end else if (pos_eff == '0) begin
                     state_in = olist_pkg::S_DEL_FRONT;
                  end else begin
                     // walk one past the victim to pick up its successor
                     steps_in = olist_pkg::count_type'(pos_eff + 1'b1);
                     del_in   = 1'b1;
                     state_in = olist_pkg::S_WALK;
                  end
               end else if (func == olist_pkg::FN_TRAVERSE && !is_empty) begin
                  steps_in = count_ff;
                  state_in = olist_pkg::S_TRAV;
               end
            end
         end

         olist_pkg::S_WALK: begin
            // one link per cycle: the read data addresses the next read
            prev2_in = prev_ff;
            prev_in  = cur_ff;
            cur_in   = link_rd_ff;
            mem_ra   = link_rd_ff;
            steps_in = olist_pkg::count_type'(steps_ff - 1'b1);
            if (steps_ff == olist_pkg::count_type'(1)) begin
               state_in = del_ff ? olist_pkg::S_DEL_LINK : olist_pkg::S_INS_NEW;
            end
         end

         olist_pkg::S_INS_FRONT: begin
            // old tail now closes the ring onto the new head
            link_we  = 1'b1;
            link_wa  = tail_ff;
            link_wd  = slot_ff;
            state_in = olist_pkg::S_RESP;
         end

         olist_pkg::S_INS_NEW: begin
            link_we  = 1'b1;
            link_wa  = slot_ff;
            link_wd  = cur_ff;
            state_in = olist_pkg::S_INS_PREV;
         end

         olist_pkg::S_INS_PREV: begin
            link_we = 1'b1;
            link_wa = prev_ff;
            link_wd = slot_ff;
            if (prev_ff == tail_ff) begin
               tail_in = slot_ff;
            end
            state_in = olist_pkg::S_RESP;
         end

         olist_pkg::S_DEL_FRONT: begin
            // link of the old head arrived from the read at acceptance
            head_in  = link_rd_ff;
            link_we  = 1'b1;
            link_wa  = tail_ff;
            link_wd  = link_rd_ff;
            free_in  = free_ff | olist_pkg::slot_bit(head_ff);
            state_in = olist_pkg::S_RESP;
         end

         olist_pkg::S_DEL_LINK: begin
            // predecessor skips the victim
            link_we = 1'b1;
            link_wa = prev2_ff;
            link_wd = cur_ff;
            if (prev_ff == tail_ff) begin
               tail_in = prev2_ff;
            end
            free_in  = free_ff | olist_pkg::slot_bit(prev_ff);
            state_in = olist_pkg::S_RESP;
         end

         olist_pkg::S_TRAV: begin
            // re-read the same slot while the output is held
            if (out_free) begin
               rsp_load       = 1'b1;
               rsp_status_in  = olist_pkg::ST_OK;
               rsp_element_in = val_rd_ff;
               rsp_last_in    = (steps_ff == olist_pkg::count_type'(1));
               cur_in         = link_rd_ff;
               mem_ra         = link_rd_ff;
               steps_in       = olist_pkg::count_type'(steps_ff - 1'b1);
               if (steps_ff == olist_pkg::count_type'(1)) begin
                  state_in = olist_pkg::S_IDLE;
               end
            end
         end

         olist_pkg::S_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = olist_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = olist_pkg::S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olist_pkg::S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= '1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      prev2_ff <= prev2_in;
      steps_ff <= steps_in;
      del_ff   <= del_in;
      if (state_ff == olist_pkg::S_IDLE && req_valid) begin
         status_ff <= status_in;
      end
      if (rsp_load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_element_ff <= rsp_element_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element       = rsp_element_ff;
   assign rsp_element_count = 6'(rsp_count_ff);
   assign rsp_last          = rsp_last_ff;

endmodule
